// ===== sv/hed_pkg.sv =====
// -----------------------------------------------------------------------------
// HTML entity decoder package
// Shared types, character codes and the named entity tables.
// -----------------------------------------------------------------------------
`default_nettype none

package hed_pkg;

	// Default depth of the held byte buffer and depth of the input queue.
	localparam int unsigned MaxHeldDefault = 16;
	localparam int unsigned QueueDepth     = 4;
	localparam int unsigned NumNamed       = 5;

	// Character codes.
	localparam logic [7:0] ChAmp   = 8'h26;
	localparam logic [7:0] ChHash  = 8'h23;
	localparam logic [7:0] ChSemi  = 8'h3B;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChQuest = 8'h3F;

	// Numeric entity value saturates here; this and above decode to '?'.
	localparam logic [7:0] NumSat = 8'd128;

	// Named entity spellings, padded with zeros, and their lengths and results.
	localparam logic [7:0] NamedText [NumNamed][8] = '{
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},  // &amp;
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},  // &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},  // &gt;
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00},  // &quot;
		'{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00}   // &nbsp;
	};
	localparam logic [2:0] NamedLen [NumNamed] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
	localparam logic [7:0] NamedResult [NumNamed] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20};

	// Character class of one byte.
	typedef struct packed {
		logic       is_amp;
		logic       is_hash;
		logic       is_semi;
		logic       is_digit;
		logic [3:0] digit;
	} byte_class_t;

	// One queued input item with its class.
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		byte_class_t cls;
	} item_t;

	// Status of the decode engine.
	typedef struct packed {
		logic idle;
		logic held_full;
	} back_status_t;

	function automatic byte_class_t classify_byte(input logic [7:0] b);
		byte_class_t c;
		logic [7:0]  d;
		d          = b - ChZero;
		c.is_amp   = (b == ChAmp);
		c.is_hash  = (b == ChHash);
		c.is_semi  = (b == ChSemi);
		c.is_digit = (b >= ChZero) && (b <= ChNine);
		c.digit    = d[3:0];
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/hed_ram.sv =====
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module hed_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/hed_front.sv =====
// -----------------------------------------------------------------------------
// HTML entity decoder front end
// Accepts input transactions, classifies each byte and queues it for the
// decode engine.
// -----------------------------------------------------------------------------
`default_nettype none

module hed_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [7:0]     s_tdata,   // in_byte
	input  wire logic           s_tlast,   // in_last
	output logic                q_valid,
	output hed_pkg::item_t      q_item,
	input  wire logic           pop
);

	import hed_pkg::*;

	localparam int unsigned QAW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QCW = $clog2(QueueDepth + 1);

	item_t          mem_q [QueueDepth];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;
	item_t          new_item;

	assign s_tready = (count_q != QCW'(QueueDepth));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	// Classify the incoming byte once, on entry to the queue.
	always_comb begin
		new_item.data = s_tdata;
		new_item.last = s_tlast;
		new_item.cls  = classify_byte(s_tdata);
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/hed_back.sv =====
// -----------------------------------------------------------------------------
// HTML entity decoder engine
// Holds the pending bytes after an '&', matches them against the named and
// numeric entities, replays held bytes after a failed match and drives the
// output register.
// -----------------------------------------------------------------------------
`default_nettype none

module hed_back #(
	parameter int unsigned MAX_HELD = hed_pkg::MaxHeldDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire hed_pkg::item_t      in_item,
	output logic                     pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // out_byte
	output logic                     m_tlast,   // out_last
	output logic                     m_tuser,   // out_end
	output hed_pkg::back_status_t    status
);

	import hed_pkg::*;

	localparam int unsigned PW = $clog2(MAX_HELD);
	localparam int unsigned CW = $clog2(MAX_HELD + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_FLUSH = 4'b1000
	} bk_state_t;

	typedef enum logic [3:0] {
		NUM_HASH   = 4'b0001,
		NUM_FIRST  = 4'b0010,
		NUM_DIGITS = 4'b0100,
		NUM_DEAD   = 4'b1000
	} num_phase_t;

	bk_state_t              state_q, state_d;
	logic [PW-1:0]          head_q, head_n;
	logic [CW-1:0]          len_q, len_n;
	logic [CW-1:0]          fed_q, fed_n, fed_inc;
	logic [NumNamed-1:0]    mask_q, mask_n;
	num_phase_t             nph_q, nph_n;
	logic [7:0]             nval_q, nval_n;
	logic                   last_q;
	logic                   stg_valid_q;
	logic [7:0]             stg_data_q;
	logic                   out_valid_q;
	logic [7:0]             out_data_q;
	logic                   out_last_q;
	logic                   out_end_q;

	logic [7:0]             ram_rdata;
	logic [PW-1:0]          rd_addr, wr_addr;
	logic                   ram_re, ram_we;

	logic [7:0]             cur_data;
	byte_class_t            cur_cls;
	logic                   cur_last;
	logic                   at_end;
	logic [CW-1:0]          work_len;
	logic [CW-1:0]          adv;
	logic                   emit;
	logic [7:0]             emit_byte;
	logic                   step_end;
	logic                   out_free;
	logic                   act;
	logic                   push, push_last, push_end;
	logic [7:0]             push_data;
	logic                   stg_load, stg_drop;

	logic [NumNamed-1:0]    hit, done;
	logic                   named_done;
	logic [7:0]             named_ch;
	num_phase_t             nph_c;
	logic [7:0]             nval_c;
	logic                   num_done;
	logic [7:0]             num_ch;
	logic [11:0]            prod;
	logic                   complete, alive;

	// Circular buffer index: base plus offset, wrapped once.
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
		input logic [CW-1:0] amt);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(amt);
		if (s >= (CW+1)'(MAX_HELD)) begin
			s = s - (CW+1)'(MAX_HELD);
		end
		return s[PW-1:0];
	endfunction

	hed_ram #(
		.WIDTH(8),
		.DEPTH(MAX_HELD)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (in_item.data),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign fed_inc  = fed_q + CW'(1);
	assign rd_addr  = wrap_add(head_q, fed_q);
	assign wr_addr  = wrap_add(head_q, len_q);
	assign out_free = !out_valid_q || m_tready;

	// Byte under evaluation: the queued item when idle, a held byte on replay.
	always_comb begin
		cur_data = in_item.data;
		cur_cls  = in_item.cls;
		cur_last = in_item.last;
		at_end   = 1'b1;
		work_len = len_q + CW'(1);
		if (state_q == ST_EXEC) begin
			cur_data = ram_rdata;
			cur_cls  = classify_byte(ram_rdata);
			cur_last = last_q;
			at_end   = (fed_inc == len_q);
			work_len = len_q;
		end
	end

	// Named entity matcher: one byte position per evaluation.
	always_comb begin
		named_done = 1'b0;
		named_ch   = ChAmp;
		for (int e = 0; e < NumNamed; e++) begin
			hit[e]  = mask_q[e] && (fed_q < CW'(NamedLen[e]))
				&& (cur_data == NamedText[e][fed_q[2:0]]);
			done[e] = hit[e] && (fed_inc == CW'(NamedLen[e]));
			if (done[e]) begin
				named_done = 1'b1;
				named_ch   = NamedResult[e];
			end
		end
	end

	// Numeric entity matcher with a saturating decimal accumulator.
	always_comb begin
		prod     = {1'b0, nval_q, 3'b000} + {3'b000, nval_q, 1'b0} + {8'h00, cur_cls.digit};
		nph_c    = NUM_DEAD;
		nval_c   = nval_q;
		num_done = 1'b0;
		num_ch   = ((nval_q != 8'd0) && (nval_q < NumSat)) ? nval_q : ChQuest;
		unique case (nph_q)
			NUM_HASH: begin
				nph_c = cur_cls.is_hash ? NUM_FIRST : NUM_DEAD;
			end
			NUM_FIRST: begin
				if (cur_cls.is_digit) begin
					nph_c  = NUM_DIGITS;
					nval_c = {4'b0000, cur_cls.digit};
				end
			end
			NUM_DIGITS: begin
				if (cur_cls.is_digit) begin
					nph_c  = NUM_DIGITS;
					nval_c = (prod > {4'b0000, NumSat}) ? NumSat : prod[7:0];
				end else if (cur_cls.is_semi) begin
					num_done = 1'b1;
				end
			end
			NUM_DEAD: begin
				nph_c = NUM_DEAD;
			end
			default: begin
				nph_c = NUM_DEAD;
			end
		endcase
	end

	// Decision for the byte under evaluation.
	always_comb begin
		complete  = named_done || num_done;
		alive     = (|hit) || (nph_c != NUM_DEAD);
		emit      = 1'b0;
		emit_byte = cur_data;
		adv       = '0;
		fed_n     = fed_q;
		mask_n    = mask_q;
		nph_n     = nph_q;
		nval_n    = nval_q;
		if (fed_q == '0) begin
			if (!cur_cls.is_amp) begin
				// Plain text at the head passes straight through.
				emit  = 1'b1;
				adv   = CW'(1);
			end else if (at_end && cur_last) begin
				// A lone '&' at the end of the string is text.
				emit      = 1'b1;
				emit_byte = ChAmp;
				adv       = CW'(1);
			end else begin
				mask_n = '1;
				nph_n  = NUM_HASH;
				nval_n = '0;
				fed_n  = CW'(1);
			end
		end else if (complete) begin
			emit      = 1'b1;
			emit_byte = named_done ? named_ch : num_ch;
			adv       = fed_inc;
			fed_n     = '0;
		end else if (!alive || (at_end && (cur_last || (fed_inc == CW'(MAX_HELD))))) begin
			// Failed match: the '&' becomes text and the rest is rescanned.
			emit      = 1'b1;
			emit_byte = ChAmp;
			adv       = CW'(1);
			fed_n     = '0;
		end else begin
			fed_n  = fed_inc;
			mask_n = hit;
			nph_n  = nph_c;
			nval_n = nval_c;
		end
		len_n    = work_len - adv;
		head_n   = wrap_add(head_q, adv);
		step_end = (fed_n == len_n);
	end

	// Sequencer and output staging. The staging register holds back one
	// result so that the last result of a transaction can be marked.
	always_comb begin
		state_d   = state_q;
		act       = 1'b0;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		push      = 1'b0;
		push_data = stg_data_q;
		push_last = 1'b0;
		push_end  = 1'b0;
		stg_load  = 1'b0;
		stg_drop  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && out_free) begin
					act     = 1'b1;
					pop     = 1'b1;
					ram_we  = 1'b1;
					state_d = step_end ? ST_IDLE : ST_READ;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					act = 1'b1;
					if (!step_end) begin
						state_d = ST_READ;
					end else if (emit && stg_valid_q) begin
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					push_end  = last_q;
					stg_drop  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (act) begin
			if (stg_valid_q) begin
				if (emit) begin
					push     = 1'b1;
					stg_load = 1'b1;
				end else if (step_end) begin
					push      = 1'b1;
					push_last = 1'b1;
					push_end  = cur_last;
					stg_drop  = 1'b1;
				end
			end else if (emit) begin
				if (step_end) begin
					push      = 1'b1;
					push_data = emit_byte;
					push_last = 1'b1;
					push_end  = cur_last;
				end else begin
					stg_load = 1'b1;
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			len_q       <= '0;
			fed_q       <= '0;
			mask_q      <= '0;
			nph_q       <= NUM_DEAD;
			nval_q      <= '0;
			last_q      <= 1'b0;
			stg_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (act) begin
				head_q <= head_n;
				len_q  <= len_n;
				fed_q  <= fed_n;
				mask_q <= mask_n;
				nph_q  <= nph_n;
				nval_q <= nval_n;
			end
			if (pop) begin
				last_q <= in_item.last;
			end
			if (stg_load) begin
				stg_valid_q <= 1'b1;
			end else if (stg_drop) begin
				stg_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (stg_load) begin
			stg_data_q <= emit_byte;
		end
		if (push) begin
			out_data_q <= push_data;
			out_last_q <= push_last;
			out_end_q  <= push_end;
		end
	end

	assign m_tvalid         = out_valid_q;
	assign m_tdata          = out_data_q;
	assign m_tlast          = out_last_q;
	assign m_tuser          = out_end_q;
	assign status.idle      = (state_q == ST_IDLE);
	assign status.held_full = (len_q == CW'(MAX_HELD));

endmodule

`default_nettype wire

// ===== sv/html_entity_decoder_unit.sv =====
// -----------------------------------------------------------------------------
// HTML entity decoder
// Decodes &amp; &lt; &gt; &quot; &nbsp; and numeric entities &#digits; in a
// byte stream. Numeric codes 1 to 127 become their character, any other code
// becomes '?'. Bytes after an '&' are held until the entity completes or can
// no longer match; on a failed match the '&' is passed as text and the held
// bytes are rescanned. A pending entity that reaches MAX_HELD bytes passes
// verbatim, and a byte with s_tlast set flushes everything held. Each input
// transaction gives zero or more output transactions; m_tlast marks the last
// one caused by an input byte and m_tuser marks the final byte of the string.
// Throughput is one byte per cycle while no match fails and the output does not
// stall. After a failed match each held byte is read back from the held-byte
// RAM and then evaluated, and a flush step follows when a replay ends with two
// results still to deliver. A four-entry input queue and an output register let
// both sides stall independently.
// -----------------------------------------------------------------------------
`default_nettype none

module html_entity_decoder_unit #(
	parameter int unsigned MAX_HELD = hed_pkg::MaxHeldDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // in_byte
	input  wire logic       s_tlast,   // in_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic            m_tlast,   // out_last
	output logic            m_tuser    // out_end
);

	import hed_pkg::*;

	logic         q_valid;
	item_t        q_item;
	logic         q_pop;
	back_status_t bk_status;

	hed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (q_pop)
	);

	hed_back #(
		.MAX_HELD(MAX_HELD)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_item  (q_item),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.status   (bk_status)
	);

	// The end-of-string mark only rides on the last result of a transaction.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end of string marked on a result that is not last");

	// The engine takes a queued byte only when one is there.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// New bytes enter only between transactions, never during a replay.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> bk_status.idle)
		else $error("queue popped while the engine is replaying");

	// A waiting pending entity is always shorter than the held buffer.
	a_held_room: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.idle |-> !bk_status.held_full)
		else $error("held buffer full while waiting for input");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// -----------------------------------------------------------------------------
// HTML entity decoder testbench
// Drives text strings one byte per transaction into the decoder and checks
// every output transaction against a cycle-free model of the decoding rules.
// Directed strings cover named and numeric entities, failed matches, long
// entities and end-of-string flushing. Random strings follow, under three
// idle patterns on the two stream sides.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HeldDepth  = 16;
	localparam int          StallLimit = 5000;
	localparam int          DrainWait  = 60;

	// Character codes used by the decoding rules.
	localparam logic [7:0] AmpChar   = 8'h26;
	localparam logic [7:0] HashChar  = 8'h23;
	localparam logic [7:0] SemiChar  = 8'h3B;
	localparam logic [7:0] ZeroChar  = 8'h30;
	localparam logic [7:0] NineChar  = 8'h39;
	localparam logic [7:0] QuestChar = 8'h3F;

	// Outcome of matching the pending bytes against an entity.
	typedef enum int {NoMatch, MaybeMatch, FullMatch} match_t;

	// One decoded output byte with its markers.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fin;
	} decoded_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;  // in_byte
	logic       s_tlast  = 1'b0;   // in_last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // out_byte
	logic       m_tlast;           // out_last
	logic       m_tuser;           // out_end

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count    = 0;
	int stall_cycles  = 0;

	string      named_text [5] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;"};
	logic [7:0] named_char [5] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20};

	// Decoder model state.
	logic [7:0] held_q [HeldDepth];
	int         held_cnt   = 0;
	int         rescan_pos = 0;

	decoded_t   expected_bytes [$];
	logic [7:0] text_q [$];

	html_entity_decoder_unit #(.MAX_HELD(HeldDepth)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic bit is_digit(input logic [7:0] c);
		return (c >= ZeroChar) && (c <= NineChar);
	endfunction

	// Match the n pending bytes starting at base against every entity form.
	function automatic match_t match_entity(input int base, input int n,
			output int len, output logic [7:0] ch);
		bit could;
		bit same;
		int ln;
		int m;
		int v;
		int i;
		could = 1'b0;
		len   = 1;
		ch    = 8'h00;
		for (int e = 0; e < 5; e++) begin
			ln   = named_text[e].len();
			m    = (n < ln) ? n : ln;
			same = 1'b1;
			for (int j = 0; j < m; j++) begin
				if (held_q[base + j] != 8'(named_text[e][j])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				if (n >= ln) begin
					len = ln;
					ch  = named_char[e];
					return FullMatch;
				end
				could = 1'b1;
			end
		end
		if (n < 2) return MaybeMatch;
		if (held_q[base + 1] != HashChar) return could ? MaybeMatch : NoMatch;
		if (n < 3) return MaybeMatch;
		if (!is_digit(held_q[base + 2])) return could ? MaybeMatch : NoMatch;
		v = 0;
		i = 2;
		while (i < n && is_digit(held_q[base + i])) begin
			v = v * 10 + int'(held_q[base + i] - ZeroChar);
			if (v > 128) v = 128;
			i++;
		end
		if (i == n) return MaybeMatch;
		if (held_q[base + i] != SemiChar) return could ? MaybeMatch : NoMatch;
		len = i + 1;
		ch  = (v >= 1 && v <= 127) ? 8'(v) : QuestChar;
		return FullMatch;
	endfunction

	// Advance the model by one input byte and queue the bytes it decodes to.
	function automatic void decode_step(input logic [7:0] b, input logic fin);
		logic [7:0] outs [HeldDepth + 1];
		int         k;
		int         n;
		int         len;
		match_t     r;
		logic [7:0] ch;
		decoded_t   item;
		k = 0;
		if (rescan_pos > held_cnt) rescan_pos = held_cnt;
		if (held_cnt >= HeldDepth) begin
			n = held_cnt - rescan_pos;
			for (int i = 0; i < n; i++) held_q[i] = held_q[rescan_pos + i];
			held_cnt   = n;
			rescan_pos = 0;
		end
		if (held_cnt < HeldDepth) begin
			held_q[held_cnt] = b;
			held_cnt++;
		end
		while (rescan_pos < held_cnt && k < HeldDepth) begin
			n = held_cnt - rescan_pos;
			if (held_q[rescan_pos] != AmpChar) begin
				outs[k] = held_q[rescan_pos];
				k++;
				rescan_pos++;
			end else begin
				r = match_entity(rescan_pos, n, len, ch);
				if (r == FullMatch) begin
					outs[k] = ch;
					k++;
					rescan_pos += len;
				end else if (r == MaybeMatch && !fin && n < HeldDepth) begin
					break;
				end else begin
					outs[k] = AmpChar;
					k++;
					rescan_pos++;
				end
			end
		end
		if (rescan_pos >= held_cnt) begin
			held_cnt   = 0;
			rescan_pos = 0;
		end
		for (int j = 0; j < k; j++) begin
			item.data = outs[j];
			item.last = (j == k - 1);
			item.fin  = (j == k - 1) && fin;
			expected_bytes.push_back(item);
		end
	endfunction

	// Predict on each input transaction, then check each output transaction.
	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) decode_step(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '{data: m_tdata, last: m_tlast, fin: m_tuser};
				if (expected_bytes.size() == 0) begin
					$display("%0t: expected none, actual %h %b %b",
						$realtime, got.data, got.last, got.fin);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (got !== want) begin
						$display("%0t: expected %h %b %b, actual %h %b %b",
							$realtime, want.data, want.last, want.fin,
							got.data, got.last, got.fin);
						fail_count++;
					end
				end
			end
		end
	end

	// The receiver stalls at random.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= StallLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Send one byte, idling first at random, and wait for its transaction.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Send the bytes of text_q as one string, the final byte marked last.
	task automatic send_queue();
		for (int i = 0; i < text_q.size(); i++) begin
			send_byte(text_q[i], i == text_q.size() - 1);
		end
		text_q.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
		send_queue();
	endtask

	function automatic void push_digits(input int count);
		for (int i = 0; i < count; i++) text_q.push_back(ZeroChar + 8'($urandom_range(0, 9)));
	endfunction

	task automatic test_named_entity();
		send_text("&lt;");
	endtask

	// Code zero and a code above the character range both give '?'.
	task automatic test_out_of_range_codes();
		send_text("&#0;");
		send_text("&#300;");
	endtask

	// A numeric entity filling the whole buffer passes verbatim.
	task automatic test_long_entity();
		send_text("&#99999999999999");
	endtask

	// A failed match rescans, and the string end flushes a pending '&'.
	task automatic test_failed_match();
		send_text("&q&");
	endtask

	task automatic test_extreme_bytes();
		send_text("\001\377");
	endtask

	// Random strings built mostly from well-formed entities and plain text.
	task automatic test_random_text(input int item_count);
		int sent;
		int tokens;
		int e;
		int ln;
		sent = 0;
		while (sent < item_count) begin
			tokens = $urandom_range(1, 6);
			for (int t = 0; t < tokens; t++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
					end
					3, 4: begin
						e = $urandom_range(0, 4);
						for (int i = 0; i < named_text[e].len(); i++)
							text_q.push_back(8'(named_text[e][i]));
					end
					5: begin
						e  = $urandom_range(0, 4);
						ln = $urandom_range(1, named_text[e].len() - 1);
						for (int i = 0; i < ln; i++) text_q.push_back(8'(named_text[e][i]));
						text_q.push_back(8'($urandom_range(1, 255)));
					end
					6, 7: begin
						text_q.push_back(AmpChar);
						text_q.push_back(HashChar);
						push_digits($urandom_range(1, 3));
						text_q.push_back(SemiChar);
					end
					8: begin
						text_q.push_back(AmpChar);
						text_q.push_back(HashChar);
						push_digits($urandom_range(0, 4));
						text_q.push_back(8'($urandom_range(1, 255)));
					end
					default: begin
						text_q.push_back(AmpChar);
						text_q.push_back(HashChar);
						push_digits($urandom_range(10, 18));
						if ($urandom_range(0, 1)) text_q.push_back(SemiChar);
					end
				endcase
			end
			sent += text_q.size();
			send_queue();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 76;
		test_named_entity();
		test_out_of_range_codes();
		test_long_entity();
		test_failed_match();
		test_extreme_bytes();
		test_random_text(70);

		send_idle_pct = 76;
		recv_idle_pct = 15;
		test_random_text(70);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(70);

		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
